// ===== rtl/ppmfd_pkg.sv =====
// ---------------------------------------------------------------------------
// ppmfd_pkg
// Shared types, register indexes and reset values for the PPM frame decoder.
// ---------------------------------------------------------------------------
package ppmfd_pkg;

  localparam int TIME_W      = 16;
  localparam int IDX_W       = 4;
  localparam int CNT_W       = 4;
  localparam int CHAN_W      = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  localparam int SLOTS_DEFAULT = 8;

  localparam logic [CNT_W-1:0]  RST_CHANNEL_COUNT = 4'd8;
  localparam logic [TIME_W-1:0] RST_MIN_WIDTH     = 16'd900;
  localparam logic [TIME_W-1:0] RST_MAX_WIDTH     = 16'd2100;
  localparam logic [TIME_W-1:0] RST_SYNC_THRESH   = 16'd8000;
  localparam logic [TIME_W-1:0] RST_TIMER_TOP     = 16'd40000;
  localparam logic [TIME_W-1:0] RST_SLOT_WIDTH    = 16'd2400;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_COUNT = 3'd0,
    REG_MIN_WIDTH     = 3'd1,
    REG_MAX_WIDTH     = 3'd2,
    REG_SYNC_THRESH   = 3'd3,
    REG_TIMER_TOP     = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    MODE_CAPTURE = 1'b0,
    MODE_READ    = 1'b1
  } mode_t;

  typedef struct packed {
    logic              en;
    logic [TIME_W-1:0] data;
  } slot_wr_t;

endpackage

// ===== rtl/ppmfd_slots.sv =====
// ---------------------------------------------------------------------------
// ppmfd_slots
// Channel width slot file: one write port, one combinational read port.
// ---------------------------------------------------------------------------
module ppmfd_slots #(
  parameter int SLOTS = ppmfd_pkg::SLOTS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ppmfd_pkg::slot_wr_t             wr,
  input  logic [$clog2(SLOTS)-1:0]        wr_addr,
  input  logic [$clog2(SLOTS)-1:0]        rd_addr,
  output logic [ppmfd_pkg::TIME_W-1:0]    rd_data
);

  logic [ppmfd_pkg::TIME_W-1:0] slot_r [SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_r[i] <= ppmfd_pkg::RST_SLOT_WIDTH;
      end
    end else if (wr.en) begin
      slot_r[wr_addr] <= wr.data;
    end
  end

  assign rd_data = slot_r[rd_addr];

endmodule

// ===== rtl/ppm_frame_decoder.sv =====
// An input transaction passes the input register, then the result register.
// Throughput: one transaction per cycle unless out_tready stalls the output;
// the slot file update and flag logic finish in the single compute stage.
// Reset: rst_n synchronous active low; config returns to defaults, slot
// index, last edge time and frame flag clear, every slot reloads 2400.
// ---------------------------------------------------------------------------
// ppm_frame_decoder
// PPM sum-signal decoder: edge intervals into channel slots, clamped reads.
// ---------------------------------------------------------------------------
module ppm_frame_decoder #(
  parameter int SLOTS = ppmfd_pkg::SLOTS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // tdata: capture_time[15:0], channel[18:16], zero pad
  input  logic [ppmfd_pkg::IN_TDATA_W-1:0]     in_tdata,
  // tuser: mode
  input  logic                                 in_tuser,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // tdata: width_us[15:0], frame_ready[16], zero pad
  output logic [ppmfd_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ppmfd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ppmfd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW = $clog2(SLOTS);
  localparam logic [ppmfd_pkg::IDX_W:0] SLOTS_V = (ppmfd_pkg::IDX_W + 1)'(SLOTS);

  // configuration
  logic [ppmfd_pkg::CNT_W-1:0]  cnt_r;
  logic [ppmfd_pkg::TIME_W-1:0] min_r, max_r, thr_r, top_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= ppmfd_pkg::RST_CHANNEL_COUNT;
      min_r <= ppmfd_pkg::RST_MIN_WIDTH;
      max_r <= ppmfd_pkg::RST_MAX_WIDTH;
      thr_r <= ppmfd_pkg::RST_SYNC_THRESH;
      top_r <= ppmfd_pkg::RST_TIMER_TOP;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ppmfd_pkg::REG_CHANNEL_COUNT: cnt_r <= cfg_data[ppmfd_pkg::CNT_W-1:0];
        ppmfd_pkg::REG_MIN_WIDTH:     min_r <= cfg_data;
        ppmfd_pkg::REG_MAX_WIDTH:     max_r <= cfg_data;
        ppmfd_pkg::REG_SYNC_THRESH:   thr_r <= cfg_data;
        ppmfd_pkg::REG_TIMER_TOP:     top_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // input stage
  logic                              s1_valid_r;
  logic                              s1_mode_r;
  logic [ppmfd_pkg::TIME_W-1:0]      s1_time_r;
  logic [ppmfd_pkg::CHAN_W-1:0]      s1_chan_r;
  logic                              out_free;
  logic                              s2_fire;
  logic                              in_fire;

  assign out_free  = !out_tvalid || out_tready;
  assign s2_fire   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s2_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r <= in_tuser;
      s1_time_r <= in_tdata[ppmfd_pkg::TIME_W-1:0];
      s1_chan_r <= in_tdata[ppmfd_pkg::TIME_W +: ppmfd_pkg::CHAN_W];
    end
  end

  // decoder state
  logic [ppmfd_pkg::TIME_W-1:0] last_r, last_nxt;
  logic [ppmfd_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic                         flag_r, flag_nxt;

  // compute stage
  logic [ppmfd_pkg::IDX_W:0]    slot_sel;
  logic [ppmfd_pkg::IDX_W:0]    slot_inc;
  logic [ppmfd_pkg::IDX_W:0]    chan_mod;
  logic [ppmfd_pkg::TIME_W-1:0] interval;
  logic [ppmfd_pkg::TIME_W-1:0] rd_data;
  logic [ppmfd_pkg::TIME_W-1:0] half;
  logic [ppmfd_pkg::TIME_W-1:0] width_nxt;
  logic                         is_sync;
  ppmfd_pkg::slot_wr_t          slot_wr;

  always_comb begin
    slot_sel = ({1'b0, idx_r} >= SLOTS_V) ? ({1'b0, idx_r} - SLOTS_V) : {1'b0, idx_r};
    slot_inc = slot_sel + 1'b1;
    chan_mod = {2'b00, s1_chan_r};
    for (int k = 0; k < 4; k++) begin
      if (chan_mod >= SLOTS_V) begin
        chan_mod = chan_mod - SLOTS_V;
      end
    end
  end

  always_comb begin
    interval = s1_time_r - last_r;
    if (s1_time_r < last_r) begin
      interval = interval + top_r;
    end
    is_sync = interval > thr_r;
  end

  ppmfd_slots #(
    .SLOTS(SLOTS)
  ) u_slots (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (slot_wr),
    .wr_addr (slot_sel[AW-1:0]),
    .rd_addr (chan_mod[AW-1:0]),
    .rd_data (rd_data)
  );

  assign half = {1'b0, rd_data[ppmfd_pkg::TIME_W-1:1]};

  always_comb begin
    last_nxt     = last_r;
    idx_nxt      = idx_r;
    flag_nxt     = flag_r;
    width_nxt    = '0;
    slot_wr.en   = 1'b0;
    slot_wr.data = interval;
    if (s2_fire) begin
      if (s1_mode_r == ppmfd_pkg::MODE_CAPTURE) begin
        last_nxt = s1_time_r;
        if (is_sync) begin
          idx_nxt = '0;
        end else begin
          slot_wr.en = 1'b1;
          idx_nxt    = slot_inc[ppmfd_pkg::IDX_W-1:0];
          if (idx_nxt >= cnt_r) begin
            flag_nxt = 1'b1;
          end
        end
      end else begin
        flag_nxt = 1'b0;
        if (half < min_r) begin
          width_nxt = min_r;
        end else if (half > max_r) begin
          width_nxt = max_r;
        end else begin
          width_nxt = half;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
      idx_r  <= '0;
      flag_r <= 1'b0;
    end else begin
      last_r <= last_nxt;
      idx_r  <= idx_nxt;
      flag_r <= flag_nxt;
    end
  end

  // result register
  logic [ppmfd_pkg::TIME_W-1:0] width_r;
  logic                         ready_r;
  logic                         out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      width_r <= width_nxt;
      ready_r <= flag_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(ppmfd_pkg::OUT_TDATA_W - ppmfd_pkg::TIME_W - 1){1'b0}},
                       ready_r, width_r};

  // checks
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, idx_r} <= SLOTS_V)
    else $error("slot index beyond slot count");

  a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s2_fire && s1_mode_r == ppmfd_pkg::MODE_READ |=> !flag_r && !out_tdata[16])
    else $error("read did not clear frame flag");

  a_capture_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s2_fire && s1_mode_r == ppmfd_pkg::MODE_CAPTURE |=> out_tdata[15:0] == '0)
    else $error("capture returned nonzero width");

  a_sync_restart: assert property (@(posedge clk) disable iff (!rst_n)
    s2_fire && s1_mode_r == ppmfd_pkg::MODE_CAPTURE && is_sync |=> idx_r == '0)
    else $error("sync edge did not restart slot index");

  a_result_order: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_free |=> s1_valid_r && $stable(s1_time_r))
    else $error("input stage lost a stalled item");

endmodule
